// ----- sv/ccc_pkg.sv -----
// Shared constants and types for the cyclic component counter.
package ccc_pkg;
  localparam int MAX_NODES = 4096;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int SIZE_W    = NODE_W + 1;
  localparam int DEG_W     = 2;
  localparam int COUNT_W   = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DEG_W-1:0]   DEG_PAIR  = 2'd2;
  localparam logic [DEG_W-1:0]   DEG_SAT   = 2'd3;

  localparam logic [1:0] KIND_EDGE = 2'd0;
  localparam logic [1:0] KIND_BAD  = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } cmd_t;
endpackage

// ----- sv/ccc_if.sv -----
// Request and result channel interfaces.
interface ccc_in_if import ccc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;
  modport source(output valid, operation, first_node, second_node, input ready);
  modport sink(input valid, operation, first_node, second_node, output ready);
endinterface

interface ccc_out_if import ccc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] cycle_components;
  logic               bad_edge_seen;
  modport source(output valid, cycle_components, bad_edge_seen, input ready);
  modport sink(input valid, cycle_components, bad_edge_seen, output ready);
endinterface

// ----- sv/cyclic_component_counter_unit.sv -----
// Top level of the cyclic component counter.
// Usage:
//  items: request channel. operation 0 loads an undirected edge between
//    first_node and second_node (zero-based); operation 1 finishes the run.
//  results: one item per finish: cycle_components, the number of components
//    whose vertices all have degree two, and bad_edge_seen, set when an edge
//    with an endpoint at or beyond node_count was dropped since the last finish.
//  cfg_we/cfg_data write node_count (values above 4096 act as 4096).
//  Requests pass a two-entry queue to a union-find engine over block memories.
//  An edge walks from each of its two ends to its leader, then links the smaller
//  tree under the larger unless both ends already share a leader; union by size
//  keeps walks at most 12 steps. The single read port of the link memory
//  serialises these steps. A finish counts each leader left marked after the leaders
//  of all vertices whose degree is not two are unmarked, then clears all stores; no
//  request is taken during that clearing pass.
//  Reset starts the same clearing pass; items.ready stays low while it runs.
//  The result sits in an output register: requests keep entering the queue
//  while results.ready is low, and the engine waits only to place a new result.
module cyclic_component_counter_unit import ccc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  ccc_in_if.sink           items,
  ccc_out_if.source        results,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);
  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] n_active;
  cmd_t             cmd;
  logic             cmd_valid, cmd_ready, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(1);
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  assign n_active = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

  ccc_front u_front (
    .clk(clk), .rst(rst), .items(items), .n_active(n_active), .hold(clearing),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  ccc_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .n_active(n_active), .clearing(clearing), .results(results)
  );
endmodule

// ----- sv/ccc_front.sv -----
// Front end: accepts requests, classifies them, and queues them for the engine.
module ccc_front import ccc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  ccc_in_if.sink           items,
  input  logic [CNT_W-1:0] n_active,
  input  logic             hold,
  output cmd_t             cmd,
  output logic             cmd_valid,
  input  logic             cmd_ready
);
  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;
  cmd_t       incoming;

  always_comb begin
    incoming.a = items.first_node;
    incoming.b = items.second_node;
    if (items.operation) begin
      incoming.kind = KIND_FIN;
    end else if ({1'b0, items.first_node} >= n_active ||
                 {1'b0, items.second_node} >= n_active) begin
      incoming.kind = KIND_BAD;
    end else begin
      incoming.kind = KIND_EDGE;
    end
  end

  assign items.ready = (cnt != 2'd2) && !hold;
  assign push        = items.valid && items.ready;
  assign cmd_valid   = (cnt != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= incoming;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- sv/ccc_back.sv -----
// Back end: union-find engine over block memories, finish scan and store clearing.
module ccc_back import ccc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  logic [CNT_W-1:0] n_active,
  output logic             clearing,
  ccc_out_if.source        results
);
  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_FIND = 5'd2;
  localparam logic [4:0] ST_E1   = 5'd3;
  localparam logic [4:0] ST_E2   = 5'd4;
  localparam logic [4:0] ST_E3   = 5'd5;
  localparam logic [4:0] ST_E4   = 5'd6;
  localparam logic [4:0] ST_E5   = 5'd7;
  localparam logic [4:0] ST_E6   = 5'd8;
  localparam logic [4:0] ST_E7   = 5'd9;
  localparam logic [4:0] ST_P1A  = 5'd10;
  localparam logic [4:0] ST_P1B  = 5'd11;
  localparam logic [4:0] ST_P1C  = 5'd12;
  localparam logic [4:0] ST_P2A  = 5'd13;
  localparam logic [4:0] ST_P2B  = 5'd14;
  localparam logic [4:0] ST_P2C  = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  logic [NODE_W-1:0] par_mem  [MAX_NODES];
  logic [SIZE_W-1:0] sz_mem   [MAX_NODES];
  logic [DEG_W-1:0]  deg_mem  [MAX_NODES];
  logic              cand_mem [MAX_NODES];

  logic [NODE_W-1:0] par_q;
  logic [SIZE_W-1:0] sz_q;
  logic [DEG_W-1:0]  deg_q;
  logic              cand_q;

  logic [NODE_W-1:0] rd_addr;
  logic              par_we, sz_we, deg_we, cand_we;
  logic [NODE_W-1:0] par_wa, sz_wa, deg_wa, cand_wa;
  logic [NODE_W-1:0] par_wd;
  logic [SIZE_W-1:0] sz_wd;
  logic [DEG_W-1:0]  deg_wd;
  logic              cand_wd;

  logic [4:0]         state, state_next, ret, ret_next;
  logic [NODE_W-1:0]  cur, cur_next, ra, ra_next, rb, rb_next;
  logic [NODE_W-1:0]  a, a_next, b, b_next, clr_idx, clr_idx_next;
  logic [SIZE_W-1:0]  sza, sza_next;
  logic [DEG_W-1:0]   degw, degw_next, deg_old;
  logic [CNT_W-1:0]   k, k_next;
  logic [COUNT_W-1:0] cnt, cnt_next, res_cnt, res_cnt_next;
  logic               bad, bad_next, res_bad, res_bad_next, ov, ov_next;

  assign clearing                 = (state == ST_CLR);
  assign cmd_ready                = (state == ST_IDLE);
  assign results.valid            = ov;
  assign results.cycle_components = res_cnt;
  assign results.bad_edge_seen    = res_bad;

  always_ff @(posedge clk) begin
    par_q  <= par_mem[rd_addr];
    sz_q   <= sz_mem[rd_addr];
    deg_q  <= deg_mem[rd_addr];
    cand_q <= cand_mem[rd_addr];
    if (par_we)  par_mem[par_wa]   <= par_wd;
    if (sz_we)   sz_mem[sz_wa]     <= sz_wd;
    if (deg_we)  deg_mem[deg_wa]   <= deg_wd;
    if (cand_we) cand_mem[cand_wa] <= cand_wd;
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    cur_next     = cur;
    ra_next      = ra;
    rb_next      = rb;
    a_next       = a;
    b_next       = b;
    clr_idx_next = clr_idx;
    sza_next     = sza;
    degw_next    = degw;
    k_next       = k;
    cnt_next     = cnt;
    bad_next     = bad;
    res_cnt_next = res_cnt;
    res_bad_next = res_bad;
    ov_next      = ov && !results.ready;
    rd_addr      = cur;
    par_we  = 1'b0; par_wa  = cur; par_wd  = cur;
    sz_we   = 1'b0; sz_wa   = cur; sz_wd   = sz_q;
    deg_we  = 1'b0; deg_wa  = a;   deg_wd  = deg_q;
    cand_we = 1'b0; cand_wa = cur; cand_wd = 1'b0;
    deg_old = deg_q;
    unique case (state)
      ST_CLR: begin
        par_we  = 1'b1; par_wa  = clr_idx; par_wd  = clr_idx;
        sz_we   = 1'b1; sz_wa   = clr_idx; sz_wd   = SIZE_W'(1);
        deg_we  = 1'b1; deg_wa  = clr_idx; deg_wd  = '0;
        cand_we = 1'b1; cand_wa = clr_idx; cand_wd = 1'b1;
        bad_next = 1'b0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          a_next = cmd.a;
          b_next = cmd.b;
          case (cmd.kind)
            KIND_EDGE: begin
              cur_next   = cmd.a;
              rd_addr    = cmd.a;
              ret_next   = ST_E1;
              state_next = ST_FIND;
            end
            KIND_BAD: bad_next = 1'b1;
            default: begin
              k_next     = '0;
              cnt_next   = '0;
              state_next = (n_active == '0) ? ST_OUT : ST_P1A;
            end
          endcase
        end
      end
      ST_FIND: begin
        if (par_q == cur) begin
          state_next = ret;
        end else begin
          cur_next = par_q;
          rd_addr  = par_q;
        end
      end
      ST_E1: begin
        ra_next    = cur;
        cur_next   = b;
        rd_addr    = b;
        ret_next   = ST_E2;
        state_next = ST_FIND;
      end
      ST_E2: begin
        rb_next = cur;
        if (ra == cur) begin
          state_next = ST_E5;
        end else begin
          rd_addr    = ra;
          state_next = ST_E3;
        end
      end
      ST_E3: begin
        sza_next   = sz_q;
        rd_addr    = rb;
        state_next = ST_E4;
      end
      ST_E4: begin
        par_we = 1'b1;
        sz_we  = 1'b1;
        sz_wd  = sza + sz_q;
        if (sza > sz_q) begin
          par_wa = rb; par_wd = ra; sz_wa = ra;
        end else begin
          par_wa = ra; par_wd = rb; sz_wa = rb;
        end
        state_next = ST_E5;
      end
      ST_E5: begin
        rd_addr    = a;
        state_next = ST_E6;
      end
      ST_E6: begin
        deg_we     = 1'b1;
        deg_wa     = a;
        deg_wd     = (deg_q == DEG_SAT) ? DEG_SAT : deg_q + 1'b1;
        degw_next  = deg_wd;
        rd_addr    = b;
        state_next = ST_E7;
      end
      ST_E7: begin
        deg_old    = (a == b) ? degw : deg_q;
        deg_we     = 1'b1;
        deg_wa     = b;
        deg_wd     = (deg_old == DEG_SAT) ? DEG_SAT : deg_old + 1'b1;
        state_next = ST_IDLE;
      end
      ST_P1A: begin
        rd_addr    = k[NODE_W-1:0];
        state_next = ST_P1B;
      end
      ST_P1B: begin
        if (deg_q == DEG_PAIR) begin
          if (k + 1'b1 == n_active) begin
            k_next = '0; state_next = ST_P2A;
          end else begin
            k_next = k + 1'b1; state_next = ST_P1A;
          end
        end else begin
          cur_next   = k[NODE_W-1:0];
          rd_addr    = k[NODE_W-1:0];
          ret_next   = ST_P1C;
          state_next = ST_FIND;
        end
      end
      ST_P1C: begin
        cand_we = 1'b1;
        cand_wa = cur;
        if (k + 1'b1 == n_active) begin
          k_next = '0; state_next = ST_P2A;
        end else begin
          k_next = k + 1'b1; state_next = ST_P1A;
        end
      end
      ST_P2A: begin
        cur_next   = k[NODE_W-1:0];
        rd_addr    = k[NODE_W-1:0];
        ret_next   = ST_P2B;
        state_next = ST_FIND;
      end
      ST_P2B: begin
        rd_addr    = cur;
        state_next = ST_P2C;
      end
      ST_P2C: begin
        if (cand_q) begin
          cand_we = 1'b1;
          cand_wa = cur;
          if (cnt != COUNT_MAX) cnt_next = cnt + 1'b1;
        end
        if (k + 1'b1 == n_active) begin
          state_next = ST_OUT;
        end else begin
          k_next = k + 1'b1; state_next = ST_P2A;
        end
      end
      ST_OUT: begin
        if (!ov || results.ready) begin
          ov_next      = 1'b1;
          res_cnt_next = cnt;
          res_bad_next = bad;
          clr_idx_next = '0;
          state_next   = ST_CLR;
        end
      end
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    ret     <= ret_next;
    cur     <= cur_next;
    ra      <= ra_next;
    rb      <= rb_next;
    a       <= a_next;
    b       <= b_next;
    sza     <= sza_next;
    degw    <= degw_next;
    k       <= k_next;
    cnt     <= cnt_next;
    res_cnt <= res_cnt_next;
    res_bad <= res_bad_next;
    if (rst) begin
      state   <= ST_CLR;
      clr_idx <= '0;
      bad     <= 1'b0;
      ov      <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      bad     <= bad_next;
      ov      <= ov_next;
    end
  end
endmodule

// ----- sv/ccc_checker.sv -----
// Port-level assertions for the cyclic component counter, bound to the top level.
module ccc_checker import ccc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] out_count,
  input logic               out_bad
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_count) && $stable(out_bad))
    else $error("result changed while stalled");

  a_rst_no_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_rst_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during clearing pass");
endmodule

bind cyclic_component_counter_unit ccc_checker u_ccc_checker (
  .clk(clk), .rst(rst), .in_ready(items.ready),
  .out_valid(results.valid), .out_ready(results.ready),
  .out_count(results.cycle_components), .out_bad(results.bad_edge_seen)
);
